// ----- design/stt_pkg.sv -----
// Shared types, token codes and lookup tables for the source text tokenizer.
package stt_pkg;

  localparam int POSITION_BITS_DEFAULT = 16;
  localparam int KEYWORD_CHARS_DEFAULT = 6;

  // Fixed widths of the token fields.
  localparam int KIND_BITS = 6;
  localparam int POS_BITS  = 16;
  localparam int ERR_BITS  = 2;

  // Result queue depth; a power of two of at least two.
  localparam int QUEUE_DEPTH = 4;

  localparam logic [KIND_BITS-1:0] KIND_END      = 6'd0;
  localparam logic [KIND_BITS-1:0] KIND_INT      = 6'd1;
  localparam logic [KIND_BITS-1:0] KIND_FLOAT    = 6'd2;
  localparam logic [KIND_BITS-1:0] KIND_STRING   = 6'd3;
  localparam logic [KIND_BITS-1:0] KIND_IDENT    = 6'd4;
  localparam logic [KIND_BITS-1:0] KIND_KEYWORD0 = 6'd5;
  localparam logic [KIND_BITS-1:0] KIND_OP0      = 6'd18;
  localparam logic [KIND_BITS-1:0] KIND_ASSIGN   = 6'd31;
  localparam logic [KIND_BITS-1:0] KIND_EQ       = 6'd32;
  localparam logic [KIND_BITS-1:0] KIND_LT       = 6'd33;
  localparam logic [KIND_BITS-1:0] KIND_LE       = 6'd34;
  localparam logic [KIND_BITS-1:0] KIND_GT       = 6'd35;
  localparam logic [KIND_BITS-1:0] KIND_GE       = 6'd36;
  localparam logic [KIND_BITS-1:0] KIND_NE       = 6'd37;
  localparam logic [KIND_BITS-1:0] KIND_ERROR    = 6'd38;

  localparam logic [ERR_BITS-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_BITS-1:0] ERR_UNTERM   = 2'd1;
  localparam logic [ERR_BITS-1:0] ERR_BANG     = 2'd2;
  localparam logic [ERR_BITS-1:0] ERR_BAD_BYTE = 2'd3;

  localparam logic [7:0] CH_END     = 8'h00;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_ASSIGN  = 8'h3D;
  localparam logic [7:0] CH_LESS    = 8'h3C;
  localparam logic [7:0] CH_GREATER = 8'h3E;
  localparam logic [7:0] CH_BANG    = 8'h21;

  localparam int KEYWORD_COUNT = 13;

  // Keywords packed first character in the low byte, zero filled above.
  localparam logic [63:0] KEYWORD_PACK [KEYWORD_COUNT] = '{
    64'h0000_0000_0074_6E69,  // int
    64'h0000_0074_616F_6C66,  // float
    64'h0000_676E_6972_7473,  // string
    64'h0000_0000_0066_6564,  // def
    64'h0000_0000_0072_6F66,  // for
    64'h0000_0000_0000_6669,  // if
    64'h0000_0000_6573_6C65,  // else
    64'h0000_6E72_7574_6572,  // return
    64'h0000_006B_6165_7262,  // break
    64'h0000_0074_6E69_7270,  // print
    64'h0000_0000_6461_6572,  // read
    64'h0000_0000_0077_656E,  // new
    64'h0000_0000_6C6C_756E   // null
  };

  // One result item as it sits in the queue.
  typedef struct packed {
    logic [KIND_BITS-1:0] token_kind;
    logic [POS_BITS-1:0]  token_line;
    logic [POS_BITS-1:0]  token_column;
    logic [POS_BITS-1:0]  token_length;
    logic [ERR_BITS-1:0]  error_kind;
    logic [7:0]           bad_byte;
    logic                 last_result;
  } token_t;

  // Results that the scanner hands to the queue in one cycle.
  typedef struct packed {
    logic   push0;
    logic   push1;
    token_t first;
    token_t second;
  } scan_push_t;

  // Single-character operators: found flag and offset from KIND_OP0.
  function automatic logic [4:0] op_lookup(input logic [7:0] c);
    logic [4:0] r;
    unique case (c)
      "+":     r = {1'b1, 4'd0};
      "-":     r = {1'b1, 4'd1};
      "*":     r = {1'b1, 4'd2};
      "/":     r = {1'b1, 4'd3};
      "%":     r = {1'b1, 4'd4};
      "(":     r = {1'b1, 4'd5};
      ")":     r = {1'b1, 4'd6};
      "{":     r = {1'b1, 4'd7};
      "}":     r = {1'b1, 4'd8};
      "[":     r = {1'b1, 4'd9};
      "]":     r = {1'b1, 4'd10};
      ",":     r = {1'b1, 4'd11};
      ";":     r = {1'b1, 4'd12};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/stt_if.sv -----
// Valid/ready channel interfaces for source bytes and tokens.
interface stt_char_if import stt_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source(output valid, output char_byte, input ready);
  modport sink(input valid, input char_byte, output ready);
endinterface

interface stt_token_if import stt_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [KIND_BITS-1:0] token_kind;
  logic [POS_BITS-1:0]  token_line;
  logic [POS_BITS-1:0]  token_column;
  logic [POS_BITS-1:0]  token_length;
  logic [ERR_BITS-1:0]  error_kind;
  logic [7:0]           bad_byte;
  logic                 last_result;

  modport source(output valid, output token_kind, output token_line, output token_column,
                 output token_length, output error_kind, output bad_byte,
                 output last_result, input ready);
  modport sink(input valid, input token_kind, input token_line, input token_column,
               input token_length, input error_kind, input bad_byte,
               input last_result, output ready);
endinterface

// ----- design/source_text_tokenizer.sv -----
// Top level of the streaming source text tokenizer.
//
// Source bytes arrive on the chars channel, one item per byte; byte 0 ends
// the text. Tokens leave on the tokens channel, one item per token, with
// kind, line, start column, length, error code, offending byte and a flag
// marking the last token caused by a given byte.
//
// A byte accepted at one clock edge is held in the input register and
// scanned from there; its tokens are written into the output queue and
// offered from it. The scanner takes one byte per cycle while the queue
// has room; that rate is set by the scanner state register, which every
// byte updates in one pass. A byte that closes a pending token and also
// forms one of its own yields two tokens, which the queue delivers in order.
//
// When the receiver stalls, tokens wait in a four-entry queue; the scanner
// keeps taking bytes while at least two entries are free and holds its
// input otherwise, so no token is dropped. Reset clears the queue and puts
// the scanner at line 1, column 1 with no token in progress.
module source_text_tokenizer import stt_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
  parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  stt_char_if.sink    chars,
  stt_token_if.source tokens
);

  // Tokens produced by the scanner in a cycle, and queue space back to it.
  scan_push_t push;
  logic       room;

  stt_scanner #(
    .POSITION_BITS (POSITION_BITS),
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_scanner (
    .clk   (clk),
    .rst   (rst),
    .chars (chars),
    .room  (room),
    .push  (push)
  );

  stt_token_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .tokens (tokens)
  );

`ifndef SYNTH
  // A second token is only ever written together with a first one.
  a_push_order: assert property (@(posedge clk) disable iff (rst)
    push.push1 |-> push.push0)
    else $error("second token pushed without a first");

  // The scanner writes only when the queue has room for two tokens.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.push0 |-> room)
    else $error("token pushed into a full queue");

  // The end token always closes the results of its byte.
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (tokens.valid && tokens.token_kind == KIND_END) |-> tokens.last_result)
    else $error("end token not marked last");

  // An error code appears exactly on error tokens.
  a_error_kind: assert property (@(posedge clk) disable iff (rst)
    tokens.valid |-> ((tokens.error_kind != ERR_NONE) == (tokens.token_kind == KIND_ERROR)))
    else $error("error code and token kind disagree");
`endif

endmodule

// ----- design/stt_scanner.sv -----
// Input byte register and the scanner state machine that turns bytes into tokens.
module stt_scanner import stt_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
  parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  stt_char_if.sink         chars,
  input  logic             room,
  output scan_push_t       push
);

  localparam int PB = POSITION_BITS;
  localparam int WB = 8 * KEYWORD_CHARS;

  typedef enum logic [3:0] {
    S_IDLE, S_INT, S_FRAC, S_WORD, S_STR, S_EQ, S_LT, S_GT, S_BANG
  } mode_t;

  mode_t         mode, mode_next;
  logic [PB-1:0] line, line_next;
  logic [PB-1:0] col, col_next;
  logic [PB-1:0] start, start_next;
  logic [PB-1:0] len, len_next;
  logic [WB-1:0] prefix, prefix_next;
  logic          too_long, too_long_next;

  logic [7:0] byte_reg;
  logic       byte_valid;
  logic       advance;

  logic   taken;
  logic   pend_v, fresh_v;
  token_t pend, fresh;

  logic [KIND_BITS-1:0] word_kind;
  logic [4:0]           op_hit;
  logic                 is_digit, is_alpha, is_wordc, is_space;

  function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
    return (&v) ? v : v + PB'(1);
  endfunction

  function automatic logic [POS_BITS-1:0] pos16(input logic [PB-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[POS_BITS-1:0];
  endfunction

  assign advance     = byte_valid && room;
  assign chars.ready = !byte_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (chars.ready) begin
      byte_valid <= chars.valid;
    end
    if (chars.ready && chars.valid) begin
      byte_reg <= chars.char_byte;
    end
  end

  assign is_digit = (byte_reg >= "0") && (byte_reg <= "9");
  assign is_alpha = ((byte_reg >= "a") && (byte_reg <= "z")) ||
                    ((byte_reg >= "A") && (byte_reg <= "Z"));
  assign is_wordc = is_digit || is_alpha || (byte_reg == CH_UNDER);
  assign is_space = (byte_reg == CH_SPACE) || ((byte_reg >= 8'd9) && (byte_reg <= 8'd13));
  assign op_hit   = op_lookup(byte_reg);

  // Keyword match on the kept prefix; long words are always identifiers.
  always_comb begin
    word_kind = KIND_IDENT;
    if (!too_long) begin
      for (int i = 0; i < KEYWORD_COUNT; i++) begin
        if (64'(prefix) == KEYWORD_PACK[i]) begin
          word_kind = KIND_KEYWORD0 + KIND_BITS'(i);
        end
      end
    end
  end

  always_comb begin
    mode_next     = mode;
    line_next     = line;
    col_next      = col;
    start_next    = start;
    len_next      = len;
    prefix_next   = prefix;
    too_long_next = too_long;
    taken         = 1'b0;
    pend_v        = 1'b0;
    fresh_v       = 1'b0;

    pend              = '0;
    pend.token_line   = pos16(line);
    pend.token_column = pos16(start);
    pend.token_length = pos16(len);
    fresh              = '0;
    fresh.token_line   = pos16(line);
    fresh.token_column = pos16(col);
    fresh.token_length = pos16(PB'(1));

    // First the token in progress, which this byte may extend or close.
    case (mode)
      S_INT, S_FRAC: begin
        if (is_digit) begin
          len_next = sat_inc(len);
          taken    = 1'b1;
        end else if (byte_reg == CH_DOT && mode == S_INT) begin
          len_next  = sat_inc(len);
          mode_next = S_FRAC;
          taken     = 1'b1;
        end else begin
          pend_v          = 1'b1;
          pend.token_kind = (mode == S_INT) ? KIND_INT : KIND_FLOAT;
          mode_next       = S_IDLE;
        end
      end
      S_WORD: begin
        if (is_wordc) begin
          if (len < PB'(KEYWORD_CHARS)) begin
            for (int j = 0; j < KEYWORD_CHARS; j++) begin
              if (len == PB'(j)) begin
                prefix_next[8*j +: 8] = byte_reg;
              end
            end
          end else begin
            too_long_next = 1'b1;
          end
          len_next = sat_inc(len);
          taken    = 1'b1;
        end else begin
          pend_v          = 1'b1;
          pend.token_kind = word_kind;
          mode_next       = S_IDLE;
        end
      end
      S_STR: begin
        if (byte_reg == CH_END) begin
          pend_v          = 1'b1;
          pend.token_kind = KIND_ERROR;
          pend.error_kind = ERR_UNTERM;
          mode_next       = S_IDLE;
        end else if (byte_reg == CH_QUOTE) begin
          pend_v          = 1'b1;
          pend.token_kind = KIND_STRING;
          mode_next       = S_IDLE;
          taken           = 1'b1;
        end else begin
          len_next = sat_inc(len);
          taken    = 1'b1;
        end
      end
      S_EQ, S_LT, S_GT, S_BANG: begin
        pend_v = 1'b1;
        pend.token_length = pos16(PB'(1));
        if (byte_reg == CH_ASSIGN) begin
          taken = 1'b1;
          pend.token_length = pos16(PB'(2));
          unique case (mode)
            S_EQ:    pend.token_kind = KIND_EQ;
            S_LT:    pend.token_kind = KIND_LE;
            S_GT:    pend.token_kind = KIND_GE;
            default: pend.token_kind = KIND_NE;
          endcase
        end else begin
          unique case (mode)
            S_EQ:    pend.token_kind = KIND_ASSIGN;
            S_LT:    pend.token_kind = KIND_LT;
            S_GT:    pend.token_kind = KIND_GT;
            default: begin
              pend.token_kind = KIND_ERROR;
              pend.error_kind = ERR_BANG;
            end
          endcase
        end
        mode_next = S_IDLE;
      end
      default: mode_next = S_IDLE;
    endcase

    // A byte not absorbed above is scanned afresh.
    if (!taken) begin
      if (byte_reg == CH_END) begin
        fresh_v            = 1'b1;
        fresh.token_kind   = KIND_END;
        fresh.token_length = '0;
        mode_next          = S_IDLE;
        line_next          = PB'(1);
        col_next           = PB'(1);
        start_next         = PB'(1);
        len_next           = '0;
        prefix_next        = '0;
        too_long_next      = 1'b0;
      end else if (is_space) begin
        mode_next = S_IDLE;
      end else if (is_digit || is_alpha || byte_reg == CH_UNDER || byte_reg == CH_QUOTE ||
                   byte_reg == CH_ASSIGN || byte_reg == CH_LESS ||
                   byte_reg == CH_GREATER || byte_reg == CH_BANG) begin
        start_next    = col;
        len_next      = PB'(1);
        prefix_next   = '0;
        too_long_next = 1'b0;
        priority if (is_digit) begin
          mode_next = S_INT;
        end else if (byte_reg == CH_QUOTE) begin
          mode_next = S_STR;
          len_next  = '0;
        end else if (byte_reg == CH_ASSIGN) begin
          mode_next = S_EQ;
        end else if (byte_reg == CH_LESS) begin
          mode_next = S_LT;
        end else if (byte_reg == CH_GREATER) begin
          mode_next = S_GT;
        end else if (byte_reg == CH_BANG) begin
          mode_next = S_BANG;
        end else begin
          mode_next   = S_WORD;
          prefix_next = WB'(byte_reg);
        end
      end else begin
        fresh_v   = 1'b1;
        mode_next = S_IDLE;
        if (op_hit[4]) begin
          fresh.token_kind = KIND_OP0 + KIND_BITS'(op_hit[3:0]);
        end else begin
          fresh.token_kind = KIND_ERROR;
          fresh.error_kind = ERR_BAD_BYTE;
          fresh.bad_byte   = byte_reg;
        end
      end
    end

    if (byte_reg != CH_END) begin
      if (byte_reg == CH_NEWLINE) begin
        line_next = sat_inc(line);
        col_next  = PB'(1);
      end else begin
        col_next = sat_inc(col);
      end
    end
  end

  always_comb begin
    push.push0  = advance && (pend_v || fresh_v);
    push.push1  = advance && pend_v && fresh_v;
    push.first  = pend_v ? pend : fresh;
    push.first.last_result = !(pend_v && fresh_v);
    push.second = fresh;
    push.second.last_result = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= S_IDLE;
      line     <= PB'(1);
      col      <= PB'(1);
      start    <= PB'(1);
      len      <= '0;
      prefix   <= '0;
      too_long <= 1'b0;
    end else if (advance) begin
      mode     <= mode_next;
      line     <= line_next;
      col      <= col_next;
      start    <= start_next;
      len      <= len_next;
      prefix   <= prefix_next;
      too_long <= too_long_next;
    end
  end

endmodule

// ----- design/stt_token_queue.sv -----
// Small result queue that takes up to two tokens a cycle and delivers one.
module stt_token_queue import stt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  scan_push_t  push,
  output logic        room,
  stt_token_if.source tokens
);

  localparam int PTR = $clog2(QUEUE_DEPTH);

  token_t           q [QUEUE_DEPTH];
  logic [PTR-1:0]   head, tail;
  logic [PTR:0]     count, count_next;
  logic             pop;
  token_t           head_item;

  assign pop  = tokens.valid && tokens.ready;
  assign room = count <= (PTR+1)'(QUEUE_DEPTH - 2);

  always_comb begin
    count_next = count;
    if (push.push0) count_next = count_next + (PTR+1)'(1);
    if (push.push1) count_next = count_next + (PTR+1)'(1);
    if (pop)        count_next = count_next - (PTR+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (pop) head <= head + PTR'(1);
      if (push.push1) begin
        tail <= tail + PTR'(2);
      end else if (push.push0) begin
        tail <= tail + PTR'(1);
      end
    end
    if (push.push0) q[tail] <= push.first;
    if (push.push1) q[tail + PTR'(1)] <= push.second;
  end

  assign head_item           = q[head];
  assign tokens.valid        = count != '0;
  assign tokens.token_kind   = head_item.token_kind;
  assign tokens.token_line   = head_item.token_line;
  assign tokens.token_column = head_item.token_column;
  assign tokens.token_length = head_item.token_length;
  assign tokens.error_kind   = head_item.error_kind;
  assign tokens.bad_byte     = head_item.bad_byte;
  assign tokens.last_result  = head_item.last_result;

endmodule
